### rtl/xor_checksum_frame_receiver_macros.svh
// Assertion macros shared by the frame receiver RTL.
// XCFR_ASSERT_CLK names its own clock and reset; XCFR_ASSERT uses clk_i and rst_ni.
`ifndef XOR_CHECKSUM_FRAME_RECEIVER_MACROS_SVH
`define XOR_CHECKSUM_FRAME_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS

`define XCFR_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define XCFR_ASSERT(lbl, prop, msg) \
  `XCFR_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`else

`define XCFR_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`define XCFR_ASSERT(lbl, prop, msg)

`endif

`endif

### rtl/xcfr_pkg.sv
`default_nettype none

package xcfr_pkg;

  // field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 16;
  localparam int unsigned TimerW = 24;
  localparam int unsigned KindW  = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = TimerW;

  // register reset values
  localparam logic [ByteW-1:0]  HeaderRst  = 8'd2;
  localparam logic [ByteW-1:0]  FooterRst  = 8'd3;
  localparam logic [LenW-1:0]   MaxLenRst  = 16'd255;
  localparam logic [TimerW-1:0] TimeoutRst = 24'd3000;
  localparam logic [TimerW-1:0] TimerMax   = {TimerW{1'b1}};

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADER  = 2'd0,
    CFG_FOOTER  = 2'd1,
    CFG_MAX_LEN = 2'd2,
    CFG_TIMEOUT = 2'd3
  } cfg_idx_e;

  // input item kind
  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  // receive phase
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_DATA   = 3'd3,
    PH_CSUM   = 3'd4,
    PH_FOOTER = 3'd5
  } phase_e;

  // result kind
  typedef enum logic [KindW-1:0] {
    KIND_BYTE       = 3'd0,
    KIND_GOOD       = 3'd1,
    KIND_BAD_CSUM   = 3'd2,
    KIND_BAD_FOOTER = 3'd3,
    KIND_TOO_LONG   = 3'd4,
    KIND_TIMEOUT    = 3'd5
  } kind_e;

  typedef struct packed {
    logic [ByteW-1:0]  header_value;
    logic [ByteW-1:0]  footer_value;
    logic [LenW-1:0]   max_length;
    logic [TimerW-1:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data;
    logic [LenW-1:0]  index;
    logic [LenW-1:0]  length;
  } result_t;

endpackage

`default_nettype wire

### rtl/xcfr_cfg_regs.sv
`default_nettype none

module xcfr_cfg_regs
  import xcfr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                we_i,
  input  wire logic [CfgIdxW-1:0]  idx_i,
  input  wire logic [CfgDataW-1:0] wdata_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q;

  // register writes, one per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_value  <= HeaderRst;
      cfg_q.footer_value  <= FooterRst;
      cfg_q.max_length    <= MaxLenRst;
      cfg_q.timeout_ticks <= TimeoutRst;
    end else if (we_i) begin
      unique case (cfg_idx_e'(idx_i))
        CFG_HEADER:  cfg_q.header_value  <= wdata_i[ByteW-1:0];
        CFG_FOOTER:  cfg_q.footer_value  <= wdata_i[ByteW-1:0];
        CFG_MAX_LEN: cfg_q.max_length    <= wdata_i[LenW-1:0];
        CFG_TIMEOUT: cfg_q.timeout_ticks <= wdata_i[TimerW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### rtl/xcfr_core.sv
`default_nettype none
`include "xor_checksum_frame_receiver_macros.svh"

module xcfr_core
  import xcfr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             in_acc_i,
  input  wire logic             in_cmd_i,
  input  wire logic [ByteW-1:0] in_byte_i,
  output logic                  res_valid_o,
  output result_t               res_o
);

  phase_e            phase_q, phase_d;
  logic [LenW-1:0]   exp_len_q, exp_len_d;
  logic [LenW-1:0]   byte_cnt_q, byte_cnt_d;
  logic [ByteW-1:0]  xor_q, xor_d;
  logic [ByteW-1:0]  csum_q, csum_d;
  logic [TimerW-1:0] timer_q, timer_d;

  logic [TimerW-1:0] timer_inc;
  logic [LenW-1:0]   len_full;
  logic [LenW-1:0]   cnt_inc;
  logic              is_tick;
  logic              timed_out;
  logic              too_long;

  // shared terms
  assign is_tick   = (in_cmd_i == CMD_TICK);
  assign timer_inc = (timer_q != TimerMax) ? timer_q + TimerW'(1) : timer_q;
  assign timed_out = (phase_q != PH_IDLE) && (timer_inc >= cfg_i.timeout_ticks);
  assign len_full  = {exp_len_q[LenW-1:ByteW], in_byte_i};
  assign too_long  = (len_full > cfg_i.max_length);
  assign cnt_inc   = byte_cnt_q + LenW'(1);

  // next state
  always_comb begin
    phase_d    = phase_q;
    exp_len_d  = exp_len_q;
    byte_cnt_d = byte_cnt_q;
    xor_d      = xor_q;
    csum_d     = csum_q;
    timer_d    = timer_q;
    if (in_acc_i) begin
      if (is_tick) begin
        if (phase_q != PH_IDLE) begin
          timer_d = timer_inc;
          if (timed_out) begin
            phase_d = PH_IDLE;
            timer_d = '0;
          end
        end
      end else begin
        unique case (phase_q)
          PH_IDLE: begin
            if (in_byte_i == cfg_i.header_value) begin
              phase_d    = PH_LEN_HI;
              exp_len_d  = '0;
              byte_cnt_d = '0;
              xor_d      = '0;
              csum_d     = '0;
              timer_d    = '0;
            end
          end
          PH_LEN_HI: begin
            exp_len_d = {in_byte_i, {ByteW{1'b0}}};
            phase_d   = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            exp_len_d = len_full;
            timer_d   = '0;
            if (too_long) begin
              phase_d = PH_IDLE;
            end else if (len_full == '0) begin
              phase_d = PH_CSUM;
            end else begin
              phase_d = PH_DATA;
            end
          end
          PH_DATA: begin
            xor_d      = xor_q ^ in_byte_i;
            byte_cnt_d = cnt_inc;
            if (cnt_inc >= exp_len_q) begin
              phase_d = PH_CSUM;
              timer_d = '0;
            end
          end
          PH_CSUM: begin
            csum_d  = in_byte_i;
            phase_d = PH_FOOTER;
            timer_d = '0;
          end
          PH_FOOTER: begin
            phase_d = PH_IDLE;
            timer_d = '0;
          end
          default: begin
            phase_d = PH_IDLE;
            timer_d = '0;
          end
        endcase
      end
    end
  end

  // result for the accepted item
  always_comb begin
    res_valid_o  = 1'b0;
    res_o.kind   = KIND_BYTE;
    res_o.data   = '0;
    res_o.index  = byte_cnt_q;
    res_o.length = exp_len_q;
    if (in_acc_i) begin
      if (is_tick) begin
        if (timed_out) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_TIMEOUT;
          if (phase_q == PH_LEN_HI || phase_q == PH_LEN_LO) begin
            res_o.length = '0;
          end
        end
      end else begin
        unique case (phase_q)
          PH_LEN_LO: begin
            if (too_long) begin
              res_valid_o  = 1'b1;
              res_o.kind   = KIND_TOO_LONG;
              res_o.index  = '0;
              res_o.length = len_full;
            end
          end
          PH_DATA: begin
            res_valid_o = 1'b1;
            res_o.data  = in_byte_i;
          end
          PH_FOOTER: begin
            res_valid_o = 1'b1;
            if (in_byte_i != cfg_i.footer_value) begin
              res_o.kind = KIND_BAD_FOOTER;
            end else if (xor_q != csum_q) begin
              res_o.kind = KIND_BAD_CSUM;
            end else begin
              res_o.kind = KIND_GOOD;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      exp_len_q  <= '0;
      byte_cnt_q <= '0;
      xor_q      <= '0;
      csum_q     <= '0;
      timer_q    <= '0;
    end else begin
      phase_q    <= phase_d;
      exp_len_q  <= exp_len_d;
      byte_cnt_q <= byte_cnt_d;
      xor_q      <= xor_d;
      csum_q     <= csum_d;
      timer_q    <= timer_d;
    end
  end

  `XCFR_ASSERT(a_res_needs_item, res_valid_o |-> in_acc_i, "result without an accepted item")
  `XCFR_ASSERT(a_payload_in_range,
               (res_valid_o && res_o.kind == KIND_BYTE) |-> (res_o.index < res_o.length),
               "payload index past declared length")
  `XCFR_ASSERT(a_status_ends_frame,
               (res_valid_o && res_o.kind != KIND_BYTE) |=> (phase_q == PH_IDLE && timer_q == '0),
               "status did not return to idle")

endmodule

`default_nettype wire

### rtl/xcfr_out_buf.sv
`default_nettype none
`include "xor_checksum_frame_receiver_macros.svh"

module xcfr_out_buf
  import xcfr_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire result_t push_res_i,
  output logic         space_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output result_t      out_res_o
);

  logic    ov_q, ov_d;
  logic    sv_q, sv_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop = ov_q && out_ready_i;

  // output register plus one skid entry
  always_comb begin
    ov_d   = ov_q;
    sv_d   = sv_q;
    out_d  = out_q;
    skid_d = skid_q;
    if (sv_q) begin
      if (pop) begin
        out_d = skid_q;
        sv_d  = 1'b0;
      end
    end else if (push_i) begin
      if (!ov_q || pop) begin
        out_d = push_res_i;
        ov_d  = 1'b1;
      end else begin
        skid_d = push_res_i;
        sv_d   = 1'b1;
      end
    end else if (pop) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
      sv_q <= sv_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign space_o     = !sv_q;
  assign out_valid_o = ov_q;
  assign out_res_o   = out_q;

  `XCFR_ASSERT(a_skid_behind_out, sv_q |-> ov_q, "skid entry held with empty output")
  `XCFR_ASSERT(a_no_push_when_full, sv_q |-> !push_i, "item pushed into full buffer")
  `XCFR_ASSERT(a_stall_fills_skid, (push_i && ov_q && !out_ready_i) |=> sv_q,
               "stalled push was dropped")

endmodule

`default_nettype wire

### rtl/xor_checksum_frame_receiver.sv
// Channel   | Dir | Handshake              | Payload
// ----------+-----+------------------------+-------------------------------------------
// s_axis    | in  | tvalid / tready        | tdata rx_byte[7:0]; tuser cmd
// m_axis    | out | tvalid / tready        | tdata data, index, length; tuser kind
// cfg       | in  | cfg_we_i (no wait)     | cfg_idx_i register, cfg_wdata_i value
//
// Each item is decoded in the cycle it is accepted; its result, if any, is registered in the
// output register or, under a stall, the skid entry. One item per clock is sustained while m_axis_tready is high.
// A two-entry output stage (register plus skid) sets the rate under stalls: tready drops
// only while both entries hold results that the sink has not taken.
// Reset is asynchronous, active low, and leaves the receiver idle with the register
// defaults in place; no clearing pass is needed.
`default_nettype none

module xor_checksum_frame_receiver
  import xcfr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input stream
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [7:0]          s_axis_tdata_i,   // [7:0] rx_byte
  input  wire logic [0:0]          s_axis_tuser_i,   // [0] cmd
  // result stream
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [39:0]              m_axis_tdata_o,   // [7:0] out_data, [23:8] out_index,
                                                     // [39:24] out_length
  output logic [2:0]               m_axis_tuser_o,   // [2:0] out_kind
  // configuration
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t    cfg;
  logic    in_acc;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    space;

  assign s_axis_tready_o = space;
  assign in_acc          = s_axis_tvalid_i && space;

  xcfr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  xcfr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_acc_i    (in_acc),
    .in_cmd_i    (s_axis_tuser_i[0]),
    .in_byte_i   (s_axis_tdata_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  xcfr_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_res_i  (res),
    .space_o     (space),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (out_res)
  );

  // pack result fields, data in the lowest bits
  assign m_axis_tdata_o = {out_res.length, out_res.index, out_res.data};
  assign m_axis_tuser_o = out_res.kind;

endmodule

`default_nettype wire
